// ===== src/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge while out of reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every rising clk edge, reset cycles included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/sito_pkg.sv =====
// Shared widths, register indexes and the pipeline word type
// for the strided index-to-offset generator. No dependencies.
package sito_pkg;

  localparam int IDX_W        = 32;
  localparam int EXT_W        = 16;
  localparam int STR_W        = 32;
  localparam int PROD_W       = EXT_W + STR_W;
  localparam int SUM_W        = PROD_W + 2;
  localparam int OFS_W        = 40;
  localparam int NUM_DIM_REGS = 4;
  localparam int DEF_MAX_DIMS = 4;

  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 32;
  localparam int OUT_DATA_W   = 48;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_BASE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_BASE = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_END         = CFG_IDX_W'(8);

  // One word moving down the pipeline
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] index;
    logic [SUM_W-1:0] total;
  } stage_t;

endpackage

// ===== src/sito_div.sv =====
// Pipelined restoring divider: one quotient bit per register stage.
// Depends on sito_pkg.
module sito_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [sito_pkg::EXT_W-1:0] extent,
  input  sito_pkg::stage_t          in_word,
  output sito_pkg::stage_t          out_word,
  output logic [sito_pkg::EXT_W-1:0] coord
);
  import sito_pkg::*;

  logic [EXT_W-1:0] divisor;
  logic             vld [0:IDX_W];
  logic [IDX_W-1:0] idx [0:IDX_W];
  logic [SUM_W-1:0] tot [0:IDX_W];
  logic [EXT_W-1:0] rem [0:IDX_W];

  // Extent of zero acts as one
  assign divisor = (extent == '0) ? EXT_W'(1) : extent;

  assign vld[0] = in_word.valid;
  assign idx[0] = in_word.index;
  assign tot[0] = in_word.total;
  assign rem[0] = '0;

  for (genvar i = 0; i < IDX_W; i++) begin : g_bit
    logic [EXT_W:0] trial;
    logic           ge;
    assign trial = {rem[i], idx[i][IDX_W-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        // dividend bits leave at the top, quotient bits enter at the bottom
        idx[i+1] <= {idx[i][IDX_W-2:0], ge};
        tot[i+1] <= tot[i];
        rem[i+1] <= ge ? EXT_W'(trial - {1'b0, divisor}) : trial[EXT_W-1:0];
      end
    end
  end

  assign out_word.valid = vld[IDX_W];
  assign out_word.index = idx[IDX_W];
  assign out_word.total = tot[IDX_W];
  assign coord          = rem[IDX_W];

endmodule

// ===== src/sito_mac.sv =====
// Two-stage multiply-accumulate: coordinate times stride, then add.
// Depends on sito_pkg.
module sito_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic [sito_pkg::EXT_W-1:0] coord,
  input  logic [sito_pkg::STR_W-1:0] stride,
  input  sito_pkg::stage_t           in_word,
  output sito_pkg::stage_t           out_word
);
  import sito_pkg::*;

  logic              p_valid;
  logic [IDX_W-1:0]  p_index;
  logic [SUM_W-1:0]  p_total;
  logic [PROD_W-1:0] product;
  logic              o_valid;
  logic [IDX_W-1:0]  o_index;
  logic [SUM_W-1:0]  o_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      p_valid <= in_word.valid;
      o_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      product <= PROD_W'(coord) * PROD_W'(stride);
      p_index <= in_word.index;
      p_total <= in_word.total;
      o_index <= p_index;
      o_total <= p_total + SUM_W'(product);
    end
  end

  assign out_word.valid = o_valid;
  assign out_word.index = o_index;
  assign out_word.total = o_total;

endmodule

// ===== src/strided_index_to_offset.sv =====
// Top level of the strided index-to-offset generator: config registers,
// per-dimension divider and MAC chain, saturating output register.
// Depends on sito_pkg, sito_div, sito_mac and assert_macros.svh.
`include "assert_macros.svh"

// Turns a linear element index into a byte offset in a strided source.
// The index is unraveled innermost dimension first: each used dimension
// has a 32-stage divider (one quotient bit per stage) and a two-stage
// multiply-accumulate, and MAX_DIMS is clamped to 1..4. One word enters
// every cycle; the whole pipe advances together and holds only while a
// finished result waits on m_axis_tready. Quotient left after the
// outermost used dimension is dropped, so that coordinate wraps modulo
// its extent; an extent of 0 counts as 1. Offsets above 2^40-1 saturate
// and set the overflow bit. Config registers (index: 0-3 extents, outer
// to inner; 4-7 byte strides) reset to extent 1, stride 0; indexes 8
// and up are ignored. Write them only while the pipe is empty.
module strided_index_to_offset #(
  parameter int MAX_DIMS = sito_pkg::DEF_MAX_DIMS
) (
  input  logic                            clk,
  input  logic                            rst,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sito_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sito_pkg::CFG_DATA_W-1:0] cfg_data,
  // input stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [sito_pkg::IDX_W-1:0]      s_axis_tdata,   // [31:0] linear_index
  // output stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [sito_pkg::OUT_DATA_W-1:0] m_axis_tdata    // [39:0] source_offset,
                                                          // [40] overflow, rest 0
);
  import sito_pkg::*;

  localparam int NUSED = (MAX_DIMS > NUM_DIM_REGS) ? NUM_DIM_REGS :
                         (MAX_DIMS < 1) ? 1 : MAX_DIMS;

  logic [EXT_W-1:0] extent_q [NUM_DIM_REGS];
  logic [STR_W-1:0] stride_q [NUM_DIM_REGS];
  logic             en;
  stage_t           chain [0:NUSED];
  logic [SUM_W-1:0] final_total;
  logic             sat;

  // Config registers: always ready, out-of-map writes drop
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_DIM_REGS; k++) begin
        extent_q[k] <= EXT_W'(1);
        stride_q[k] <= '0;
      end
    end else if (cfg_valid) begin
      if (cfg_index < REG_STRIDE_BASE) begin
        extent_q[2'(cfg_index - REG_EXTENT_BASE)] <= cfg_data[EXT_W-1:0];
      end else if (cfg_index < REG_END) begin
        stride_q[2'(cfg_index - REG_STRIDE_BASE)] <= cfg_data[STR_W-1:0];
      end
    end
  end

  // Advance the whole pipe unless the output word is held
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  assign chain[0].valid = s_axis_tvalid;
  assign chain[0].index = s_axis_tdata;
  assign chain[0].total = '0;

  // Innermost dimension first
  for (genvar k = 0; k < NUSED; k++) begin : g_dim
    localparam int D = NUM_DIM_REGS - 1 - k;
    stage_t           div_word;
    logic [EXT_W-1:0] coord;

    sito_div u_div (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .extent   (extent_q[D]),
      .in_word  (chain[k]),
      .out_word (div_word),
      .coord    (coord)
    );

    sito_mac u_mac (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .coord    (coord),
      .stride   (stride_q[D]),
      .in_word  (div_word),
      .out_word (chain[k+1])
    );
  end

  // Saturate into the output register; leftover quotient is dropped
  assign final_total = chain[NUSED].total;
  assign sat         = |final_total[SUM_W-1:OFS_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= chain[NUSED].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {(OUT_DATA_W - OFS_W - 1)'(0), sat,
                       sat ? {OFS_W{1'b1}} : final_total[OFS_W-1:0]};
    end
  end

  `ASSERT_CLK(a_sat_all_ones,
    m_axis_tvalid && m_axis_tdata[OFS_W] |-> m_axis_tdata[OFS_W-1:0] == {OFS_W{1'b1}},
    "overflow set without saturated offset")
  `ASSERT_CLK(a_pad_zero,
    m_axis_tvalid |-> m_axis_tdata[OUT_DATA_W-1:OFS_W+1] == '0,
    "nonzero pad bits in output word")
  `ASSERT_CLK_ALWAYS(a_reset_empty,
    rst |=> !m_axis_tvalid,
    "output valid right after reset")

endmodule
